// ===== sv/rtcg_pkg.sv =====
// rtcg_pkg: shared types, constants and the glyph ramp for the terminal color mapper
// no dependencies; used by rtcg_map and the top level

package rtcg_pkg;

  // number of brightness levels in the glyph ramp (2..16)
  localparam int unsigned RAMP_LEVELS = 12;

  // luma full scale: 1000 * 255 with weights 299/587/114
  localparam int unsigned LUMA_FULL = 255000;
  localparam int unsigned LUMA_W    = 18;

  // configuration register map
  localparam int unsigned CFG_ADDR_W     = 3;
  localparam int unsigned CFG_DATA_W     = 32;
  localparam logic        REG_GRAY_TOL   = 1'b0;  // word address of gray_tolerance
  localparam logic [7:0]  GRAY_TOL_RESET = 8'd5;

  // palette anchors
  localparam logic [7:0] CUBE_BASE  = 8'd16;
  localparam logic [7:0] GRAY_FIRST = 8'd232;
  localparam logic [7:0] GRAY_LAST  = 8'd255;

  // one result item
  typedef struct packed {
    logic [7:0] color_index;
    logic [6:0] glyph_code;
    logic [3:0] glyph_level;
    logic       is_gray;
  } rtcg_res_t;

  // ascii ramp " .-=+*x#$&X@", padded with the last character
  function automatic logic [6:0] ramp_char(input logic [3:0] level);
    logic [6:0] ch;
    unique case (level)
      4'd0:    ch = 7'h20;  // space
      4'd1:    ch = 7'h2e;  // .
      4'd2:    ch = 7'h2d;  // -
      4'd3:    ch = 7'h3d;  // =
      4'd4:    ch = 7'h2b;  // +
      4'd5:    ch = 7'h2a;  // *
      4'd6:    ch = 7'h78;  // x
      4'd7:    ch = 7'h23;  // #
      4'd8:    ch = 7'h24;  // $
      4'd9:    ch = 7'h26;  // &
      4'd10:   ch = 7'h58;  // X
      default: ch = 7'h40;  // @
    endcase
    return ch;
  endfunction

endpackage

// ===== sv/rtcg_if.sv =====
// rtcg_if: valid/ready channel interfaces for pixels and mapped results
// no dependencies; the result fields are declared here and not taken from rtcg_pkg

interface rtcg_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rtcg_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] color_index;
  logic [6:0] glyph_code;
  logic [3:0] glyph_level;
  logic       is_gray;

  modport source (output valid, output color_index, output glyph_code,
                  output glyph_level, output is_gray, input ready);
  modport sink   (input valid, input color_index, input glyph_code,
                  input glyph_level, input is_gray, output ready);
endinterface

// ===== sv/rtcg_map.sv =====
// rtcg_map: combinational pixel mapper (gray test, xterm-256 index, luma glyph)
// depends on rtcg_pkg

module rtcg_map (
  input  logic [7:0]           red,
  input  logic [7:0]           green,
  input  logic [7:0]           blue,
  input  logic [7:0]           gray_tol,
  output rtcg_pkg::rtcg_res_t  res
);

  // ceil(c / 51): number of cube thresholds the channel passes
  function automatic logic [2:0] cube_level(input logic [7:0] c);
    logic [2:0] lv;
    priority if (c > 8'd204) lv = 3'd5;
    else if (c > 8'd153)     lv = 3'd4;
    else if (c > 8'd102)     lv = 3'd3;
    else if (c > 8'd51)      lv = 3'd2;
    else if (c > 8'd0)       lv = 3'd1;
    else                     lv = 3'd0;
    return lv;
  endfunction

  localparam int unsigned LUMA_W_L = rtcg_pkg::LUMA_W;

  logic [7:0]  d_rg, d_rb, d_gb;
  logic        gray;
  logic [2:0]  lv_r, lv_g, lv_b;
  logic [7:0]  cube_idx;
  logic [7:0]  gray_off;
  logic [15:0] gray_prod;
  logic [4:0]  gray_q;
  logic [7:0]  gray_idx;
  logic [LUMA_W_L-1:0] luma;
  logic [rtcg_pkg::RAMP_LEVELS-2:0] lvl_hit;
  logic [3:0]  level;

  // pairwise channel distances
  assign d_rg = (red > green)  ? red - green  : green - red;
  assign d_rb = (red > blue)   ? red - blue   : blue - red;
  assign d_gb = (green > blue) ? green - blue : blue - green;
  assign gray = (d_rg <= gray_tol) && (d_rb <= gray_tol) && (d_gb <= gray_tol);

  // 6x6x6 cube index
  assign lv_r     = cube_level(red);
  assign lv_g     = cube_level(green);
  assign lv_b     = cube_level(blue);
  assign cube_idx = rtcg_pkg::CUBE_BASE + 8'd36 * {5'd0, lv_r} + 8'd6 * {5'd0, lv_g}
                  + {5'd0, lv_b};

  // gray ramp: (red - 3) / 10 by reciprocal 205/2048, exact below 1029
  assign gray_off  = red - 8'd3;
  assign gray_prod = {8'd0, gray_off} * 16'd205;
  assign gray_q    = gray_prod[15:11];
  always_comb begin
    priority if (red < 8'd8)   gray_idx = rtcg_pkg::GRAY_FIRST;
    else if (gray_q > 5'd23)   gray_idx = rtcg_pkg::GRAY_LAST;
    else                       gray_idx = rtcg_pkg::GRAY_FIRST + {3'd0, gray_q};
  end

  // weighted luma, 299r + 587g + 114b
  assign luma = LUMA_W_L'(18'd299 * {10'd0, red})
              + LUMA_W_L'(18'd587 * {10'd0, green})
              + LUMA_W_L'(18'd114 * {10'd0, blue});

  // level k reached when (levels-1) * luma >= k * full scale; thresholds fixed at elaboration
  for (genvar k = 1; k < rtcg_pkg::RAMP_LEVELS; k++) begin : g_lvl
    localparam int unsigned THR =
      (k * rtcg_pkg::LUMA_FULL + rtcg_pkg::RAMP_LEVELS - 2) / (rtcg_pkg::RAMP_LEVELS - 1);
    assign lvl_hit[k-1] = (luma >= LUMA_W_L'(THR));
  end

  // count thresholds passed
  always_comb begin
    level = 4'd0;
    for (int i = 0; i < rtcg_pkg::RAMP_LEVELS - 1; i++) begin
      level = level + {3'd0, lvl_hit[i]};
    end
  end

  // pack result
  assign res.color_index = gray ? gray_idx : cube_idx;
  assign res.glyph_code  = rtcg_pkg::ramp_char(level);
  assign res.glyph_level = level;
  assign res.is_gray     = gray;

endmodule

// ===== sv/rgb_to_terminal_color_and_glyph_top.sv =====
// rgb_to_terminal_color_and_glyph_top: pixel to xterm-256 color and ascii glyph
// depends on rtcg_pkg, rtcg_pix_if, rtcg_res_if and rtcg_map
//
//  port     | dir | kind            | carries
//  in_pix   | in  | valid/ready     | red, green, blue
//  out_res  | out | valid/ready     | color_index, glyph_code, glyph_level, is_gray
//  psel ... | in  | apb write/read  | gray_tolerance at byte address 0
//
// one pixel per cycle sustained while out_res is ready; a pixel passes in order through
// the input register, the mapper logic and the result register
// rst_n clears both stage valids and sets gray_tolerance to 5
// a stalled result holds in the result register while the input register still
// takes a pixel; input ready drops only when both stages are full and out is stalled

module rgb_to_terminal_color_and_glyph_top (
  input  logic                               clk,
  input  logic                               rst_n,
  rtcg_pix_if.sink                           in_pix,
  rtcg_res_if.source                         out_res,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rtcg_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [rtcg_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [rtcg_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready
);

  logic                 tol_wr;
  logic [7:0]           tol_r;
  logic [7:0]           tol_nxt;
  logic                 s1_vld_r;
  logic [7:0]           red_r;
  logic [7:0]           green_r;
  logic [7:0]           blue_r;
  logic                 res_vld_r;
  rtcg_pkg::rtcg_res_t  res_r;
  rtcg_pkg::rtcg_res_t  map_res;
  logic                 res_take;
  logic                 in_take;

  // configuration register
  assign pready  = 1'b1;
  assign tol_wr  = psel && penable && pwrite && (paddr[2] == rtcg_pkg::REG_GRAY_TOL);
  assign tol_nxt = tol_wr ? pwdata[7:0] : tol_r;
  assign prdata  = (paddr[2] == rtcg_pkg::REG_GRAY_TOL) ? {24'd0, tol_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= rtcg_pkg::GRAY_TOL_RESET;
    end else begin
      tol_r <= tol_nxt;
    end
  end

  // stage handshakes
  assign res_take     = !res_vld_r || out_res.ready;
  assign in_pix.ready = !s1_vld_r || res_take;
  assign in_take      = in_pix.valid && in_pix.ready;

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      if (in_pix.ready) s1_vld_r <= in_pix.valid;
      if (res_take) res_vld_r <= s1_vld_r;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_take) begin
      red_r   <= in_pix.red;
      green_r <= in_pix.green;
      blue_r  <= in_pix.blue;
    end
  end

  // mapper
  rtcg_map u_map (
    .red      (red_r),
    .green    (green_r),
    .blue     (blue_r),
    .gray_tol (tol_r),
    .res      (map_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (res_take && s1_vld_r) begin
      res_r <= map_res;
    end
  end

  assign out_res.valid       = res_vld_r;
  assign out_res.color_index = res_r.color_index;
  assign out_res.glyph_code  = res_r.glyph_code;
  assign out_res.glyph_level = res_r.glyph_level;
  assign out_res.is_gray     = res_r.is_gray;

`ifndef ASSERT_OFF
  // gray flag agrees with the palette region of the index
  a_gray_region: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld_r |-> (res_r.is_gray == (res_r.color_index >= rtcg_pkg::GRAY_FIRST)))
    else $error("gray flag and color index region disagree");

  // glyph code follows its level and the level stays on the ramp
  a_glyph: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld_r |-> ((res_r.glyph_code == rtcg_pkg::ramp_char(res_r.glyph_level)) &&
                   (res_r.glyph_level <= 4'(rtcg_pkg::RAMP_LEVELS - 1))))
    else $error("glyph code or level out of step");

  // a pixel moving out of the input register lands in the result register
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && res_take) |=> res_vld_r)
    else $error("pixel lost between stages");

  // a stalled pixel stays in the input register with its red and blue unchanged
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !res_take) |=> (s1_vld_r && $stable(red_r) && $stable(blue_r)))
    else $error("stalled pixel dropped or changed");
`endif

endmodule
